// ----- src/fcv_pkg.sv -----
// shared types and constants of the full linear convolution unit
package fcv_pkg;

  localparam int VAL_W    = 16;  // q1.15 sample and coefficient
  localparam int IDX_W    = 5;   // coefficient index field
  localparam int LEN_W    = 6;   // kernel length register
  localparam int PROD_W   = 32;  // q2.30 product
  localparam int OUT_W    = 37;  // result with guard bits
  localparam int GRP_SIZE = 8;   // products added per first-level group

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } front_state_t;

  typedef struct packed {
    logic vld;
    logic last;
  } stage_ctl_t;

endpackage

// ----- src/fcv_if.sv -----
// valid/ready channel interfaces for input items and results
interface fcv_in_if import fcv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        coef_index;
  logic signed [VAL_W-1:0] value;
  logic                    last_sample;

  modport src  (output valid, output action, output coef_index, output value,
                output last_sample, input ready);
  modport sink (input valid, input action, input coef_index, input value,
                input last_sample, output ready);
endinterface

interface fcv_out_if import fcv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] result_value;
  logic                    last_result;

  modport src  (output valid, output result_value, output last_result, input ready);
  modport sink (input valid, input result_value, input last_result, output ready);
endinterface

// ----- src/fcv_tree.sv -----
// registered adder tree over the tap products, saturation and result register
module fcv_tree import fcv_pkg::*; #(
  parameter int TAPS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [PROD_W-1:0] prod [TAPS],
  input  stage_ctl_t               in_ctl,
  output logic                     in_ready,
  fcv_out_if.src                   out_ch
);

  localparam int NGRP  = (TAPS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int RAW_W = PROD_W + $clog2(TAPS);
  localparam int SUM_W = (RAW_W > OUT_W) ? RAW_W : OUT_W;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(OUT_MIN);

  logic signed [SUM_W-1:0] grp_nxt [NGRP];
  logic signed [SUM_W-1:0] grp_r   [NGRP];
  stage_ctl_t              gctl_r;

  logic signed [SUM_W-1:0] total;
  logic signed [OUT_W-1:0] sat_val;
  logic                    out_adv;

  logic                    out_vld_r;
  logic                    out_last_r;
  logic signed [OUT_W-1:0] out_val_r;

  assign out_adv  = !out_vld_r || out_ch.ready;
  assign in_ready = !gctl_r.vld || out_adv;

  // first level: groups of products, padded taps past the end count as zero
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < TAPS) begin
          grp_nxt[g] = grp_nxt[g] + SUM_W'(prod[g * GRP_SIZE + j]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + grp_r[g];
    end
    if (total > SAT_MAX) begin
      sat_val = OUT_MAX;
    end else if (total < SAT_MIN) begin
      sat_val = OUT_MIN;
    end else begin
      sat_val = total[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gctl_r <= '0;
    end else if (in_ready) begin
      gctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ctl.vld) begin
      grp_r <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r  <= gctl_r.vld;
      out_last_r <= gctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && gctl_r.vld) begin
      out_val_r <= sat_val;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.last_result  = out_last_r;

`ifndef SYNTHESIS
  a_grp_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ctl.vld && in_ready |=> gctl_r.vld)
    else $error("group stage lost an item");

  a_out_take: assert property (@(posedge clk) disable iff (!rst_n)
    gctl_r.vld && out_adv |=> out_vld_r)
    else $error("result register lost an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=>
      out_vld_r && $stable(out_val_r) && $stable(out_last_r))
    else $error("result changed while stalled");
`endif

endmodule

// ----- src/full_linear_convolution_unit.sv -----
// top level of the full linear convolution unit
//
// in_ch carries load items (action 0: coefficient value at coef_index) and
// sample items (action 1). Every sample gives one result on out_ch; a sample
// with last_sample set is followed by kernel_length-1 further results with
// zeros shifted in, the final one flagged by last_result, after which the
// history is cleared for the next signal.
// cfg_we/cfg_wdata write kernel_length (0 acts as 1, values above TAPS as
// TAPS); write it only while no results are outstanding.
// The result of a sample passes the product register, the group-sum register
// and the result register before it leaves on out_ch.
// Throughput: one item per cycle while out_ch does not stall; after a last
// sample the input is held off while the flush results (one fewer than the
// taps in use) are issued, and longer if out_ch stalls.
// Reset clears the history, the flush sequencer, the pipeline valids and sets
// kernel_length to 1; coefficients must be loaded before use.
// When out_ch stalls, the pipeline fills its empty stages and then holds
// in_ch.ready low; no result is dropped.
module full_linear_convolution_unit import fcv_pkg::*; #(
  parameter int TAPS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  fcv_in_if.sink           in_ch,
  fcv_out_if.src           out_ch,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  localparam int KIDX_W = $clog2(TAPS);
  localparam int MW     = $clog2(TAPS + 1);
  localparam int CNT_W  = $clog2(TAPS);

  logic [LEN_W-1:0]        len_r;
  logic signed [VAL_W-1:0] kernel_r [TAPS];
  logic signed [VAL_W-1:0] hist_r   [TAPS-1];

  front_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic signed [PROD_W-1:0] prod_nxt [TAPS];
  logic signed [PROD_W-1:0] prod_r   [TAPS];
  stage_ctl_t               pctl_r;

  logic                    tree_ready;
  logic                    p_adv;
  logic [MW-1:0]           m_use;
  logic                    in_xfer;
  logic                    load_xfer;
  logic                    samp_xfer;
  logic                    flush_issue;
  logic                    issue;
  logic                    issue_last;
  logic signed [VAL_W-1:0] tap_x;
  logic [KIDX_W+IDX_W-1:0] idx_ext;

  assign p_adv     = !pctl_r.vld || tree_ready;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign load_xfer = in_xfer && (in_ch.action == ACT_LOAD);
  assign samp_xfer = in_xfer && (in_ch.action == ACT_SAMPLE);
  assign idx_ext   = {{KIDX_W{1'b0}}, in_ch.coef_index};

  // taps in use
  always_comb begin
    if (len_r == '0) begin
      m_use = MW'(1);
    end else if (int'(len_r) > TAPS) begin
      m_use = MW'(TAPS);
    end else begin
      m_use = MW'(len_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_RUN: begin
        if (samp_xfer && in_ch.last_sample && (m_use != MW'(1))) begin
          state_nxt = ST_FLUSH;
          cnt_nxt   = CNT_W'(m_use - MW'(1));
        end
      end
      ST_FLUSH: begin
        if (p_adv) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_RUN) && p_adv;
    flush_issue = (state_r == ST_FLUSH) && p_adv;
    issue       = samp_xfer || flush_issue;
    issue_last  = flush_issue ? (cnt_r == CNT_W'(1))
                              : (in_ch.last_sample && (m_use == MW'(1)));
    tap_x       = flush_issue ? '0 : in_ch.value;
  end

  // one product per tap, taps past the length in use give zero
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      if (MW'(t) < m_use) begin
        if (t == 0) begin
          prod_nxt[t] = tap_x * kernel_r[t];
        end else begin
          prod_nxt[t] = hist_r[t-1] * kernel_r[t];
        end
      end else begin
        prod_nxt[t] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
      len_r   <= LEN_RESET;
      pctl_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (p_adv) begin
        pctl_r.vld  <= issue;
        pctl_r.last <= issue_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= prod_nxt;
    end
  end

  // history shifts on every issued item and clears after the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_r[i] <= '0;
      end
    end else if (issue) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        if (issue_last) begin
          hist_r[i] <= '0;
        end else if (i == 0) begin
          hist_r[i] <= tap_x;
        end else begin
          hist_r[i] <= hist_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_xfer && (int'(in_ch.coef_index) < TAPS)) begin
      kernel_r[idx_ext[KIDX_W-1:0]] <= in_ch.value;
    end
  end

  fcv_tree #(
    .TAPS (TAPS)
  ) u_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .prod     (prod_r),
    .in_ctl   (pctl_r),
    .in_ready (tree_ready),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> cnt_r != '0)
    else $error("flush with no outputs left");

  a_flush_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && p_adv |=> pctl_r.vld)
    else $error("flush cycle issued no item");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    issue && issue_last |=> state_r == ST_RUN)
    else $error("sequencer still flushing after final output");
`endif

endmodule
